@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/fqs_pkg.sv @@
`default_nettype none

package fqs_pkg;

  // Request codes carried on the mode port.
  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  // Result status codes.
  localparam logic [1:0] RES_DONE  = 2'd0;
  localparam logic [1:0] RES_EMPTY = 2'd1;
  localparam logic [1:0] RES_FULL  = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_WAIT,
    S_SCAN
  } state_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUSH,
    OP_REJECT_FULL,
    OP_REJECT_EMPTY,
    OP_PLAIN,
    OP_READ_HEAD,
    OP_POP_DONE,
    OP_SCAN_STEP,
    OP_SCAN_DONE
  } dp_op_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/fqs_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fqs_ctrl.sv @@
`default_nettype none

// Request sequencer: picks the datapath command for each cycle.
module fqs_ctrl import fqs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] mode,
  input  dp_stat_t   stat,
  output dp_op_t     op,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (mode_t'(mode))
            MODE_PUSH: begin
              op = stat.full ? OP_REJECT_FULL : OP_PUSH;
            end
            MODE_POP: begin
              if (stat.empty) begin
                op = OP_REJECT_EMPTY;
              end else begin
                op         = OP_READ_HEAD;
                state_next = S_POP_WAIT;
              end
            end
            MODE_SEARCH: begin
              if (stat.empty) begin
                op = OP_PLAIN;
              end else begin
                op         = OP_READ_HEAD;
                state_next = S_SCAN;
              end
            end
            default: begin
              op = OP_PLAIN;
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        op         = OP_POP_DONE;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (stat.hit || stat.last) begin
          op         = OP_SCAN_DONE;
          state_next = S_IDLE;
        end else begin
          op = OP_SCAN_STEP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/fqs_dp.sv @@
`default_nettype none

// Queue pointers, entry store, search scan and result registers.
module fqs_dp import fqs_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dp_op_t                     op,
  input  logic [31:0]                value,
  output dp_stat_t                   stat,
  output logic                       done,
  output logic [1:0]                 status,
  output logic                       found,
  output logic signed [31:0]         removed_value,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] scan_pos;
  logic [CW-1:0] held;
  logic [CW-1:0] scan_left;
  logic [31:0]   key;
  logic [31:0]   removed;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign ram_we    = (op == OP_PUSH);
  assign ram_re    = (op == OP_READ_HEAD) || (op == OP_SCAN_STEP);
  assign ram_raddr = (op == OP_READ_HEAD) ? head : scan_pos;

  fqs_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign stat.empty = (held == '0);
  assign stat.full  = (held == CW'(DEPTH));
  assign stat.hit   = (ram_rdata == key);
  assign stat.last  = (scan_left == '0);

  // Pointers, occupancy and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      held <= '0;
      done <= 1'b0;
    end else begin
      done <= (op == OP_PUSH) || (op == OP_REJECT_FULL) || (op == OP_REJECT_EMPTY) ||
              (op == OP_PLAIN) || (op == OP_POP_DONE) || (op == OP_SCAN_DONE);
      case (op)
        OP_PUSH: begin
          tail <= wrap_inc(tail);
          held <= held + CW'(1);
        end
        OP_POP_DONE: begin
          head <= wrap_inc(head);
          held <= held - CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Scan registers and result payload.
  always_ff @(posedge clk) begin
    case (op)
      OP_PUSH: begin
        status  <= RES_DONE;
        found   <= 1'b0;
        removed <= '0;
        count   <= held + CW'(1);
      end
      OP_REJECT_FULL: begin
        status  <= RES_FULL;
        found   <= 1'b0;
        removed <= '0;
        count   <= held;
      end
      OP_REJECT_EMPTY: begin
        status  <= RES_EMPTY;
        found   <= 1'b0;
        removed <= '0;
        count   <= held;
      end
      OP_PLAIN: begin
        status  <= RES_DONE;
        found   <= 1'b0;
        removed <= '0;
        count   <= held;
      end
      OP_READ_HEAD: begin
        key       <= value;
        scan_pos  <= wrap_inc(head);
        scan_left <= held - CW'(1);
      end
      OP_SCAN_STEP: begin
        scan_pos  <= wrap_inc(scan_pos);
        scan_left <= scan_left - CW'(1);
      end
      OP_POP_DONE: begin
        status  <= RES_DONE;
        found   <= 1'b0;
        removed <= ram_rdata;
        count   <= held - CW'(1);
      end
      OP_SCAN_DONE: begin
        status  <= RES_DONE;
        found   <= stat.hit;
        removed <= '0;
        count   <= held;
      end
      default: begin
      end
    endcase
  end

  assign removed_value = $signed(removed);

endmodule

`default_nettype wire

@@ hw/rtl/fifo_queue_with_search.sv @@
`default_nettype none

// Bounded first-in first-out queue of 32-bit words with a search request.
// A request is taken at a clock edge where start is high and busy is low.
// Its result appears on the result registers with done high for exactly one cycle;
// the receiver cannot stall, so the result must be captured in that cycle.
// Push, a rejected push or pop, a search of an empty queue and the unused
// mode 3 finish without leaving the idle state and busy stays low, so such
// requests may be issued on every cycle. A successful pop passes through
// S_POP_WAIT (busy is high for one cycle), because the entry store is a RAM
// with a registered read port. A search reads the held words through that
// single read port, one per cycle from the head, and stops at the first
// match or after the last held word; busy stays high while it scans.
// The entry store needs no clearing after reset; only held entries are read.
module fifo_queue_with_search import fqs_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [1:0]                 mode,
  input  logic signed [31:0]         value,
  output logic                       busy,
  output logic                       done,
  output logic [1:0]                 status,
  output logic                       found,
  output logic signed [31:0]         removed_value,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  // Command and status between the sequencer and the datapath.
  dp_op_t   op;
  dp_stat_t stat;

  // The sequencer decodes the request beat and walks pops and searches
  // through their read cycles.
  fqs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .op    (op),
    .busy  (busy)
  );

  // The datapath owns the ring pointers, the entry RAM and the result
  // registers, which drive the result ports directly.
  fqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .value         (value),
    .stat          (stat),
    .done          (done),
    .status        (status),
    .found         (found),
    .removed_value (removed_value),
    .count         (count)
  );

endmodule

`default_nettype wire

@@ hw/rtl/fqs_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the queue's result beats.
module fqs_checker import fqs_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 mode,
  input logic                       done,
  input logic [1:0]                 status,
  input logic                       found,
  input logic signed [31:0]         removed_value,
  input logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int CW = $clog2(DEPTH+1);

  // A push always answers in the following cycle.
  `ASSERT_NEXT(a_push_answers, clk, rst, start && !busy && mode == MODE_PUSH, done,
               "push request gave no result beat in the next cycle")

  // A push is refused only when the queue holds DEPTH words.
  `ASSERT_IMPLIES(a_full_count, clk, rst, done && status == RES_FULL,
                  count == CW'(DEPTH), "full status with count below DEPTH")

  // A pop is refused only when the queue is empty.
  `ASSERT_IMPLIES(a_empty_count, clk, rst, done && status == RES_EMPTY,
                  count == '0, "empty status with nonzero count")

  // Rejected requests carry no word and no match.
  `ASSERT_IMPLIES(a_reject_clean, clk, rst, done && status != RES_DONE,
                  removed_value == '0 && !found, "rejected request carries payload")

endmodule

bind fifo_queue_with_search fqs_checker #(
  .DEPTH (DEPTH)
) u_fqs_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .mode          (mode),
  .done          (done),
  .status        (status),
  .found         (found),
  .removed_value (removed_value),
  .count         (count)
);

`default_nettype wire
